### hdl/hedu_pkg.sv
// Shared types, character codes and entity tables for the HTML entity decoder.
// No dependencies; every other file in hdl/ imports this package.
package hedu_pkg;

   localparam int HOLD_DEPTH_DEFAULT = 8;
   localparam int NUM_ENT            = 13;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ENT_NBSP, ENT_AMP, ENT_LT, ENT_GT, ENT_QUOT, ENT_COPY, ENT_REG,
      ENT_RAQUO, ENT_LAQUO, ENT_BULL, ENT_MIDDOT, ENT_NDASH, ENT_MDASH
   } ent_id_type;

   // What the byte under the scan pointer does
   typedef enum logic [2:0] {
      ACT_PASS,   // no reference open, byte goes out as is
      ACT_HOLD,   // byte opens or extends a reference
      ACT_NUM,    // ';' closes a decimal reference
      ACT_NAMED,  // byte closes a named entity
      ACT_MISS    // no candidate left or no room to hold: '&' out, held bytes rescanned
   } act_type;

   typedef struct packed {
      logic load;
      logic proc;
      logic rep;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      act_type act;
      logic    queue_one;
      logic    queue_zero;
      logic    last;
      logic    rep_final;
      logic    flush_final;
      logic    out_free;
   } dp_status_type;

   // Name length counts the closing ';' but not the '&'
   function automatic logic [3:0] ent_name_len(input ent_id_type ent);
      logic [3:0] len;
      case (ent)
         ENT_NBSP:   len = 4'd5;
         ENT_AMP:    len = 4'd4;
         ENT_LT:     len = 4'd3;
         ENT_GT:     len = 4'd3;
         ENT_QUOT:   len = 4'd5;
         ENT_COPY:   len = 4'd5;
         ENT_REG:    len = 4'd4;
         ENT_RAQUO:  len = 4'd6;
         ENT_LAQUO:  len = 4'd6;
         ENT_BULL:   len = 4'd5;
         ENT_MIDDOT: len = 4'd7;
         ENT_NDASH:  len = 4'd6;
         ENT_MDASH:  len = 4'd6;
         default:    len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_name_char(input ent_id_type ent, input logic [2:0] pos);
      logic [55:0] str;
      logic [7:0]  ch;
      int          sh;
      case (ent)
         ENT_NBSP:   str = "nbsp;";
         ENT_AMP:    str = "amp;";
         ENT_LT:     str = "lt;";
         ENT_GT:     str = "gt;";
         ENT_QUOT:   str = "quot;";
         ENT_COPY:   str = "copy;";
         ENT_REG:    str = "reg;";
         ENT_RAQUO:  str = "raquo;";
         ENT_LAQUO:  str = "laquo;";
         ENT_BULL:   str = "bull;";
         ENT_MIDDOT: str = "middot;";
         ENT_NDASH:  str = "ndash;";
         ENT_MDASH:  str = "mdash;";
         default:    str = '0;
      endcase
      ch = 8'h00;
      sh = int'(ent_name_len(ent)) - 1 - int'(pos);
      if (sh >= 0) begin
         ch = str[8*sh +: 8];
      end
      return ch;
   endfunction

   function automatic logic [1:0] ent_rep_len(input ent_id_type ent);
      logic [1:0] len;
      case (ent)
         ENT_COPY, ENT_REG:                len = 2'd3;
         ENT_RAQUO, ENT_LAQUO, ENT_MDASH:  len = 2'd2;
         default:                          len = 2'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_rep_char(input ent_id_type ent, input logic [1:0] pos);
      logic [23:0] str;
      logic [7:0]  ch;
      int          sh;
      case (ent)
         ENT_NBSP:   str = " ";
         ENT_AMP:    str = "&";
         ENT_LT:     str = "<";
         ENT_GT:     str = ">";
         ENT_QUOT:   str = "\"";
         ENT_COPY:   str = "(c)";
         ENT_REG:    str = "(r)";
         ENT_RAQUO:  str = ">>";
         ENT_LAQUO:  str = "<<";
         ENT_BULL:   str = "*";
         ENT_MIDDOT: str = ".";
         ENT_NDASH:  str = "-";
         ENT_MDASH:  str = "--";
         default:    str = '0;
      endcase
      ch = 8'h00;
      sh = int'(ent_rep_len(ent)) - 1 - int'(pos);
      if (sh >= 0) begin
         ch = str[8*sh +: 8];
      end
      return ch;
   endfunction

endpackage

### hdl/hedu_ctrl.sv
// Sequencer for the entity decoder: load, scan, replacement and flush phases.
// Depends on hedu_pkg (command/status structs, action codes).
module hedu_ctrl
   import hedu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_PROC, ST_REP, ST_FLUSH} state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      emits;

   assign emits = (status.act == ACT_PASS) || (status.act == ACT_NUM) ||
                  (status.act == ACT_MISS);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            // only stall the scan when this byte has to leave
            if (status.out_free || !emits) begin
               cmd.proc = 1'b1;
               case (status.act)
                  ACT_NAMED: state_in = ST_REP;
                  ACT_HOLD: begin
                     if (status.queue_one) begin
                        state_in = status.last ? ST_FLUSH : ST_IDLE;
                     end
                  end
                  ACT_PASS, ACT_NUM: begin
                     if (status.queue_one) begin
                        state_in = ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_REP: begin
            if (status.out_free) begin
               cmd.rep = 1'b1;
               if (status.rep_final) begin
                  state_in = status.queue_zero ? ST_IDLE : ST_PROC;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               if (status.flush_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      req_ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

### hdl/hedu_dpath.sv
// Datapath: circular hold/rescan buffer, entity candidate mask, decimal
// accumulator and output register. Depends on hedu_pkg.
module hedu_dpath
   import hedu_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int PW = $clog2(HOLD_DEPTH);
   localparam int CW = $clog2(HOLD_DEPTH + 1);

   // Held bytes start at head; unscanned bytes follow from scan on.
   // scan always equals head + hold count, modulo the depth.
   logic [7:0]         buf_ff [HOLD_DEPTH];
   logic [PW-1:0]      head_ff, head_in, scan_ff, scan_in;
   logic [PW-1:0]      head_nx, scan_nx, rd_addr;
   logic [CW-1:0]      hold_cnt_ff, hold_cnt_in, queue_cnt_ff, queue_cnt_in;
   logic [CW-1:0]      k;
   logic [NUM_ENT-1:0] cand_ff, cand_in, hit, done_hit;
   logic               num_mode_ff, num_mode_in;
   logic [7:0]         num_val_ff, num_val_in, num_next;
   ent_id_type         ent_ff, ent_in, done_ent;
   logic [1:0]         rep_idx_ff, rep_idx_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [7:0]         cur;
   logic [3:0]         nlen;
   logic               hold_room, is_digit, out_free, rep_final, emit;
   rsp_type            emit_data;
   act_type            act;

   assign head_nx  = (head_ff == PW'(HOLD_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign scan_nx  = (scan_ff == PW'(HOLD_DEPTH - 1)) ? '0 : scan_ff + 1'b1;
   // with nothing left to scan, the port serves the flush from head
   assign rd_addr  = (queue_cnt_ff == '0) ? head_ff : scan_ff;
   assign cur      = buf_ff[rd_addr];
   assign k        = hold_cnt_ff - CW'(1);
   assign hold_room = hold_cnt_ff < CW'(HOLD_DEPTH);
   assign is_digit = (cur >= CH_ZERO) && (cur <= CH_NINE);
   assign num_next = (num_val_ff << 3) + (num_val_ff << 1) + (cur - CH_ZERO);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rep_final = rep_idx_ff == (ent_rep_len(ent_ff) - 2'd1);

   always_comb begin
      hit      = '0;
      done_hit = '0;
      done_ent = ENT_NBSP;
      nlen     = '0;
      for (int i = 0; i < NUM_ENT; i++) begin
         nlen = ent_name_len(ent_id_type'(4'(i)));
         hit[i] = cand_ff[i] && (CW'(nlen) > k) &&
                  (ent_name_char(ent_id_type'(4'(i)), k[2:0]) == cur);
         done_hit[i] = hit[i] && (CW'(nlen) == hold_cnt_ff);
         if (done_hit[i]) begin
            done_ent = ent_id_type'(4'(i));
         end
      end
   end

   always_comb begin
      if (hold_cnt_ff == '0) begin
         act = (cur == CH_AMP) ? ACT_HOLD : ACT_PASS;
      end else if (|done_hit) begin
         act = ACT_NAMED;
      end else if (|hit) begin
         act = hold_room ? ACT_HOLD : ACT_MISS;
      end else if ((hold_cnt_ff == CW'(1)) && (cur == CH_HASH) && hold_room) begin
         act = ACT_HOLD;
      end else if (num_mode_ff && (cur == CH_SEMI)) begin
         act = ACT_NUM;
      end else if (num_mode_ff && is_digit && hold_room) begin
         act = ACT_HOLD;
      end else begin
         act = ACT_MISS;
      end
   end

   always_comb begin
      head_in      = head_ff;
      scan_in      = scan_ff;
      hold_cnt_in  = hold_cnt_ff;
      queue_cnt_in = queue_cnt_ff;
      cand_in      = cand_ff;
      num_mode_in  = num_mode_ff;
      num_val_in   = num_val_ff;
      ent_in       = ent_ff;
      rep_idx_in   = rep_idx_ff;
      last_in      = last_ff;
      emit         = 1'b0;
      emit_data    = '0;

      if (cmd.load) begin
         queue_cnt_in = CW'(1);
         last_in      = req_data.in_last;
      end

      if (cmd.proc) begin
         case (act)
            ACT_PASS: begin
               head_in      = scan_nx;
               scan_in      = scan_nx;
               queue_cnt_in = queue_cnt_ff - CW'(1);
               emit         = 1'b1;
               emit_data    = '{out_byte: cur, out_last: last_ff && status.queue_one};
            end
            ACT_HOLD: begin
               scan_in      = scan_nx;
               hold_cnt_in  = hold_cnt_ff + CW'(1);
               queue_cnt_in = queue_cnt_ff - CW'(1);
               if (hold_cnt_ff == '0) begin
                  cand_in     = '1;
                  num_mode_in = 1'b0;
                  num_val_in  = '0;
               end else if (|hit) begin
                  cand_in = hit;
               end else if (num_mode_ff) begin
                  num_val_in = num_next;
               end else begin
                  cand_in     = '0;
                  num_mode_in = 1'b1;
                  num_val_in  = '0;
               end
            end
            ACT_NUM: begin
               head_in      = scan_nx;
               scan_in      = scan_nx;
               hold_cnt_in  = '0;
               queue_cnt_in = queue_cnt_ff - CW'(1);
               num_mode_in  = 1'b0;
               emit         = 1'b1;
               emit_data    = '{out_byte: num_val_ff, out_last: last_ff && status.queue_one};
            end
            ACT_NAMED: begin
               head_in      = scan_nx;
               scan_in      = scan_nx;
               hold_cnt_in  = '0;
               queue_cnt_in = queue_cnt_ff - CW'(1);
               num_mode_in  = 1'b0;
               ent_in       = done_ent;
               rep_idx_in   = '0;
            end
            ACT_MISS: begin
               // send the '&' out and rescan the rest of the held bytes
               head_in      = head_nx;
               scan_in      = head_nx;
               hold_cnt_in  = '0;
               queue_cnt_in = hold_cnt_ff + queue_cnt_ff - CW'(1);
               num_mode_in  = 1'b0;
               emit         = 1'b1;
               emit_data    = '{out_byte: CH_AMP, out_last: 1'b0};
            end
            default: ;
         endcase
      end

      if (cmd.rep) begin
         rep_idx_in = rep_idx_ff + 2'd1;
         emit       = 1'b1;
         emit_data  = '{out_byte: ent_rep_char(ent_ff, rep_idx_ff),
                        out_last: last_ff && status.queue_zero && rep_final};
      end

      if (cmd.flush) begin
         head_in     = head_nx;
         hold_cnt_in = hold_cnt_ff - CW'(1);
         emit        = 1'b1;
         emit_data   = '{out_byte: cur, out_last: last_ff && status.flush_final};
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         scan_ff      <= '0;
         hold_cnt_ff  <= '0;
         queue_cnt_ff <= '0;
         num_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         scan_ff      <= scan_in;
         hold_cnt_ff  <= hold_cnt_in;
         queue_cnt_ff <= queue_cnt_in;
         num_mode_ff  <= num_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      num_val_ff <= num_val_in;
      ent_ff     <= ent_in;
      rep_idx_ff <= rep_idx_in;
      last_ff    <= last_in;
      rsp_ff     <= rsp_in;
      if (cmd.load) begin
         buf_ff[scan_ff] <= req_data.in_byte;
      end
   end

   assign status = '{act:         act,
                     queue_one:   queue_cnt_ff == CW'(1),
                     queue_zero:  queue_cnt_ff == '0,
                     last:        last_ff,
                     rep_final:   rep_final,
                     flush_final: hold_cnt_ff == CW'(1),
                     out_free:    out_free};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/html_entity_decoder_unit.sv
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_ready  | req_type {in_byte, in_last}
// rsp     | out | rsp_valid/rsp_ready  | rsp_type {out_byte, out_last}
//
// A byte is taken while idle and then scanned; the next byte is taken only once
// the previous one is through. A mismatch sends the '&' out, and each held byte
// after it and the mismatching byte are scanned again. While the output is free,
// a named entity gives one replacement byte per cycle, and at the last mark the
// held bytes are flushed one per cycle. The hold buffer has a single read port.
// Reset is synchronous; req_ready rises the cycle after reset is released.
// While rsp_ready is low the output register holds and the scan waits only
// when a byte has to leave.
// Top level: sequencer plus datapath. Depends on hedu_pkg, hedu_ctrl, hedu_dpath.
module html_entity_decoder_unit
   import hedu_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   hedu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hedu_dpath #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/hedu_checker.sv
// Port-level checks for html_entity_decoder_unit, attached by bind.
// Depends on hedu_pkg and the top level's port list.
module hedu_checker
   import hedu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // one item in flight: ready drops after every input transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous item still at work");

   // an offered input waits unchanged until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input changed or dropped before transfer");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("ports active straight after reset");

endmodule

bind html_entity_decoder_unit hedu_checker u_hedu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/html_entity_decoder_unit_test.sv
// Self-checking bench for html_entity_decoder_unit: a directed table and then random text
// streams, checked against a local decoder model. Needs only hedu_pkg and the decoder RTL.
module html_entity_decoder_unit_test
   import hedu_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD = HOLD_DEPTH_DEFAULT;

   // Bytes of want are read from the low end first
   typedef struct packed {
      logic [7:0]  text;
      logic        last;
      logic        typed;
      logic [1:0]  n_want;
      logic [23:0] want;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   stim_row_type script [$];
   rsp_type decoded_bytes [$];
   rsp_type step_out [$];

   logic [7:0] held_bytes [HOLD];
   int         held_count = 0;
   logic [7:0] dec_value = '0;

   int  errors = 0;
   int  sent_count = 0;
   int  got_count = 0;
   int  squeeze_cycles = 0;
   bit  feed_done = 1'b0;

   stim_row_type directed_table [0:27] = '{
      {8'h00,   1'b0, 1'b1, 2'd1, {16'h0, 8'h00}},
      {8'hFF,   1'b1, 1'b1, 2'd1, {16'h0, 8'hFF}},
      {CH_AMP,  1'b0, 1'b1, 2'd0, 24'h0},
      {"l",     1'b0, 1'b1, 2'd0, 24'h0},
      {"t",     1'b0, 1'b1, 2'd0, 24'h0},
      {CH_SEMI, 1'b0, 1'b1, 2'd1, {16'h0, "<"}},
      {CH_AMP,  1'b0, 1'b1, 2'd0, 24'h0},
      {CH_HASH, 1'b0, 1'b1, 2'd0, 24'h0},
      {CH_SEMI, 1'b0, 1'b1, 2'd1, {16'h0, 8'h00}},
      {CH_AMP,  1'b0, 1'b1, 2'd0, 24'h0},
      {CH_HASH, 1'b0, 1'b1, 2'd0, 24'h0},
      {"0",     1'b0, 1'b1, 2'd0, 24'h0},
      {"3",     1'b0, 1'b1, 2'd0, 24'h0},
      {"0",     1'b0, 1'b1, 2'd0, 24'h0},
      {"0",     1'b0, 1'b1, 2'd0, 24'h0},
      {CH_SEMI, 1'b0, 1'b1, 2'd1, {16'h0, 8'h2C}},
      {CH_AMP,  1'b0, 1'b1, 2'd0, 24'h0},
      {CH_HASH, 1'b0, 1'b1, 2'd0, 24'h0},
      {"1",     1'b0, 1'b1, 2'd0, 24'h0},
      {"2",     1'b0, 1'b1, 2'd0, 24'h0},
      {"3",     1'b0, 1'b1, 2'd0, 24'h0},
      {"4",     1'b0, 1'b1, 2'd0, 24'h0},
      {"5",     1'b0, 1'b1, 2'd0, 24'h0},
      {"6",     1'b0, 1'b1, 2'd0, 24'h0},
      {"7",     1'b0, 1'b0, 2'd0, 24'h0},
      {CH_AMP,  1'b0, 1'b1, 2'd0, 24'h0},
      {8'h00,   1'b0, 1'b1, 2'd2, {8'h0, 8'h00, CH_AMP}},
      {CH_AMP,  1'b1, 1'b1, 2'd1, {16'h0, CH_AMP}}
   };

   html_entity_decoder_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Name includes the closing ';', not the '&'
   function automatic void entity_row(input int idx, output string nm, output string rp);
      case (idx)
         0:       begin nm = "nbsp;";   rp = " ";   end
         1:       begin nm = "amp;";    rp = "&";   end
         2:       begin nm = "lt;";     rp = "<";   end
         3:       begin nm = "gt;";     rp = ">";   end
         4:       begin nm = "quot;";   rp = "\"";  end
         5:       begin nm = "copy;";   rp = "(c)"; end
         6:       begin nm = "reg;";    rp = "(r)"; end
         7:       begin nm = "raquo;";  rp = ">>";  end
         8:       begin nm = "laquo;";  rp = "<<";  end
         9:       begin nm = "bull;";   rp = "*";   end
         10:      begin nm = "middot;"; rp = ".";   end
         11:      begin nm = "ndash;";  rp = "-";   end
         default: begin nm = "mdash;";  rp = "--";  end
      endcase
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      rsp_type r;
      if (step_out.size() < HOLD + 1) begin
         r.out_byte = b;
         r.out_last = 1'b0;
         step_out.push_back(r);
      end
   endfunction

   function automatic void drop_reference();
      held_count = 0;
      dec_value  = '0;
   endfunction

   function automatic void hold_byte(input logic [7:0] b);
      held_bytes[held_count] = b;
      held_count++;
   endfunction

   // Returns 0 when b cannot continue the open reference
   function automatic bit scan_byte(input logic [7:0] b);
      string nm, rp;
      int    k, i, j;
      bit    prefix_ok;
      if (held_count == 0) begin
         if (b == CH_AMP) begin
            hold_byte(b);
            dec_value = '0;
         end else begin
            put_byte(b);
         end
         return 1'b1;
      end
      k = held_count - 1;
      for (i = 0; i < 13; i++) begin
         entity_row(i, nm, rp);
         if (nm.len() > k && nm[k] == b) begin
            prefix_ok = 1'b1;
            for (j = 0; j < k; j++) begin
               if (nm[j] != held_bytes[j + 1]) prefix_ok = 1'b0;
            end
            if (prefix_ok) begin
               if (k + 1 == nm.len()) begin
                  for (j = 0; j < rp.len(); j++) put_byte(rp[j]);
                  drop_reference();
                  return 1'b1;
               end
               if (held_count < HOLD) begin
                  hold_byte(b);
                  return 1'b1;
               end
               return 1'b0;
            end
         end
      end
      if (k == 0 && b == CH_HASH && held_count < HOLD) begin
         hold_byte(b);
         dec_value = '0;
         return 1'b1;
      end
      if (k >= 1 && held_bytes[1] == CH_HASH) begin
         if (b == CH_SEMI) begin
            put_byte(dec_value);
            drop_reference();
            return 1'b1;
         end
         if (b >= CH_ZERO && b <= CH_NINE && held_count < HOLD) begin
            hold_byte(b);
            dec_value = 8'(dec_value * 10 + (b - CH_ZERO));
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Decoded bytes for one input byte land in step_out
   function automatic void decode_step(input req_type item);
      logic [7:0] pending [$];
      logic [7:0] b;
      rsp_type    tail;
      int         i;
      step_out.delete();
      pending.push_back(item.in_byte);
      while (pending.size() != 0) begin
         b = pending.pop_front();
         if (!scan_byte(b)) begin
            // '&' goes out, everything after it is scanned again
            put_byte(held_bytes[0]);
            pending.push_front(b);
            for (i = held_count - 1; i >= 1; i--) pending.push_front(held_bytes[i]);
            drop_reference();
         end
      end
      if (item.in_last) begin
         for (i = 0; i < held_count; i++) put_byte(held_bytes[i]);
         drop_reference();
         if (step_out.size() > 0) begin
            tail = step_out.pop_back();
            tail.out_last = 1'b1;
            step_out.push_back(tail);
         end
      end
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return CH_AMP;
         1:       return CH_SEMI;
         2:       return CH_HASH;
         3:       return 8'(CH_ZERO + $urandom_range(0, 9));
         4:       return 8'("a" + $urandom_range(0, 25));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_text(input logic [7:0] b);
      stim_row_type row;
      row      = '0;
      row.text = b;
      row.last = ($urandom_range(0, 39) == 0);
      script.push_back(row);
   endfunction

   function automatic void end_text();
      stim_row_type row;
      row      = script.pop_back();
      row.last = 1'b1;
      script.push_back(row);
   endfunction

   // Mostly complete references with random content, the rest broken ones and noise
   function automatic void compose_random_text(input int count);
      string nm, rp;
      int    kind, cut, n, i, start;
      start = script.size();
      while (script.size() - start < count) begin
         kind = $urandom_range(0, 99);
         entity_row($urandom_range(0, 12), nm, rp);
         if (kind < 35) begin
            push_text(CH_AMP);
            for (i = 0; i < nm.len(); i++) push_text(nm[i]);
         end else if (kind < 55) begin
            push_text(CH_AMP);
            push_text(CH_HASH);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
            for (i = 0; i < n; i++) push_text(8'(CH_ZERO + $urandom_range(0, 9)));
            push_text(CH_SEMI);
         end else if (kind < 72) begin
            // name cut short by a stray byte
            push_text(CH_AMP);
            cut = $urandom_range(0, nm.len() - 1);
            for (i = 0; i < cut; i++) push_text(nm[i]);
            push_text(noise_byte());
         end else if (kind < 80) begin
            cut = $urandom_range(0, nm.len() - 1);
            push_text(CH_AMP);
            for (i = 0; i < nm.len(); i++) push_text((i == cut) ? noise_byte() : nm[i]);
         end else begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++) begin
               push_text($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : noise_byte());
            end
         end
         if ($urandom_range(0, 9) == 0) end_text();
      end
      end_text();
   endfunction

   initial begin : main
      int i;
      for (i = 0; i < 28; i++) script.push_back(directed_table[i]);
      compose_random_text(172);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (feed_done);
      while (decoded_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Fed %0d text bytes (28 from the table, the rest random), checked %0d decoded",
               sent_count, got_count);
      $display("bytes; output held off once for %0d cycles, %0d mismatches",
               squeeze_cycles, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : sender
      stim_row_type row;
      req_type item;
      rsp_type r;
      int      gap, i;
      while (reset) @(posedge clock);
      while (script.size() != 0) begin
         row = script.pop_front();
         item.in_byte = row.text;
         item.in_last = row.last;
         gap = (sent_count >= 120 && sent_count < 170) ? 0 : idle_span();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         decode_step(item);
         if (row.typed) begin
            step_out.delete();
            for (i = 0; i < row.n_want; i++) begin
               r.out_byte = row.want[8*i +: 8];
               r.out_last = row.last && (i == row.n_want - 1);
               step_out.push_back(r);
            end
         end
         foreach (step_out[j]) decoded_bytes.push_back(step_out[j]);
         req_valid <= 1'b1;
         req_data  <= item;
         do @(posedge clock); while (!req_ready);
         sent_count++;
      end
      req_valid <= 1'b0;
      feed_done = 1'b1;
   end

   // Ready toggles at random; one long hold-off lets the decoder back up
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_cycles == 0 && sent_count >= 40) begin
            squeeze_cycles = 150;
            stall = squeeze_cycles;
         end else if (sent_count >= 60 && sent_count < 100) begin
            stall = 0;
         end else begin
            stall = idle_span();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got_count++;
         if (decoded_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual byte %h last %b",
                     $time, rsp_data.out_byte, rsp_data.out_last);
         end else begin
            want = decoded_bytes.pop_front();
            if (want.out_byte !== rsp_data.out_byte) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %h, actual %h",
                        $time, want.out_byte, rsp_data.out_byte);
            end
            if (want.out_last !== rsp_data.out_last) begin
               errors++;
               $display("%0t: out_last mismatch, expected %b, actual %b",
                        $time, want.out_last, rsp_data.out_last);
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timed out with %0d decoded bytes outstanding", decoded_bytes.size());
      $display("FAIL");
      $finish;
   end

endmodule
